[hw/rtl/integer_to_ascii_radix_macros.svh]
// Assertion macros used by the checker file of integer_to_ascii_radix.
// Needs clock and reset signals in the scope where the macros are used.
`ifndef INTEGER_TO_ASCII_RADIX_MACROS_SVH
`define INTEGER_TO_ASCII_RADIX_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define I2A_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("i2a assertion failed: same-cycle implication");

// Next-cycle implication, off while reset is high.
`define I2A_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("i2a assertion failed: next-cycle implication");

`endif

[hw/rtl/i2a_pkg.sv]
// Package for integer_to_ascii_radix: payload types, character constants,
// divider status type and the digit-to-ASCII mapping. No dependencies.
`default_nettype none

package i2a_pkg;

   localparam int WORD_BITS_DEFAULT = 32;

   // Field widths of the transfer payloads
   localparam int VALUE_W  = 32;
   localparam int RADIX_W  = 6;
   localparam int CHAR_W   = 7;

   localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
   localparam logic [RADIX_W-1:0] RADIX_DEC = 6'd10;
   localparam logic [RADIX_W-1:0] DIGIT_TEN = 6'd10;

   localparam logic [CHAR_W-1:0] CHAR_MINUS  = 7'h2D;
   localparam logic [CHAR_W-1:0] CHAR_ZERO   = 7'h30;
   // 'A' minus ten, so that digit value ten maps to 'A'
   localparam logic [CHAR_W-1:0] CHAR_LETTER = 7'h37;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [RADIX_W-1:0] radix;
      logic               signed_mode;
   } req_payload_type;

   typedef struct packed {
      logic [CHAR_W-1:0] character;
      logic              last;
   } rsp_payload_type;

   // Divider status toward the sequencer
   typedef struct packed {
      logic done;       // one-cycle pulse, quotient and remainder valid
      logic quo_zero;   // quotient is zero
   } div_status_type;

   function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
      logic [CHAR_W-1:0] dw;
      dw = CHAR_W'(d);
      if (d < DIGIT_TEN) begin
         return dw + CHAR_ZERO;
      end else begin
         return dw + CHAR_LETTER;
      end
   endfunction

endpackage

`default_nettype wire

[hw/rtl/i2a_div.sv]
// Iterative restoring divider: WORD_BITS-bit dividend by a 6-bit base,
// one quotient bit per cycle. Depends on i2a_pkg.
`default_nettype none

module i2a_div
   import i2a_pkg::*;
#(
   parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [WORD_BITS-1:0] dividend,
   input  wire logic [RADIX_W-1:0]   divisor,
   output logic      [WORD_BITS-1:0] quotient,
   output logic      [RADIX_W-1:0]   remainder,
   output div_status_type            status
);

   localparam int CNT_W = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;

   logic [WORD_BITS-1:0] quo_ff, quo_in;
   logic [RADIX_W-1:0]   rem_ff, rem_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   logic [RADIX_W:0]     rem_shift;
   logic                 fits;

   // One shift-subtract step
   always_comb begin
      rem_shift = {rem_ff, quo_ff[WORD_BITS-1]};
      fits      = rem_shift >= {1'b0, divisor};
   end

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = CNT_W'(WORD_BITS - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[WORD_BITS-2:0], fits};
         rem_in = fits ? RADIX_W'(rem_shift - {1'b0, divisor}) : RADIX_W'(rem_shift);
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   assign quotient        = quo_ff;
   assign remainder       = rem_ff;
   assign status.done     = done_ff;
   assign status.quo_zero = (quo_ff == '0);

endmodule

`default_nettype wire

[hw/rtl/i2a_digit_stack.sv]
// Digit store: one write port, one registered read port, WORD_BITS entries.
// Digits go in least significant first and are read back in reverse. Depends on i2a_pkg.
`default_nettype none

module i2a_digit_stack
   import i2a_pkg::*;
#(
   parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                wr_en,
   input  wire logic [$clog2(WORD_BITS)-1:0]        wr_addr,
   input  wire logic [RADIX_W-1:0]                  wr_data,
   input  wire logic                                rd_en,
   input  wire logic [$clog2(WORD_BITS)-1:0]        rd_addr,
   output logic      [RADIX_W-1:0]                  rd_data
);

   logic [RADIX_W-1:0] mem [WORD_BITS];
   logic [RADIX_W-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hw/rtl/integer_to_ascii_radix.sv]
// integer_to_ascii_radix: converts one word into ASCII digits in base 2..36.
// Uses i2a_pkg, i2a_div and i2a_digit_stack.
//
// Usage:
//   req channel (req_valid/req_ready/req_payload) takes value, radix and
//   signed_mode. A radix below 2 acts as 2, above 36 as 36. In base ten with
//   signed_mode set and the top bit set, a '-' leads the magnitude's digits.
//   rsp channel (rsp_valid/rsp_ready/rsp_payload) gives one character per
//   transfer, most significant digit first; last marks the final one.
//   Each digit takes one pass of the shared shift-subtract divider, and each
//   character goes through the digit store's registered read port.
//   req_ready is high only when no conversion is in progress; the next
//   request may be taken while the final character still waits on rsp.
//   A stalled receiver holds rsp_valid and rsp_payload and pauses the
//   character readout; no character is dropped.
//   Reset (synchronous, active high) returns to idle and clears rsp_valid.
`default_nettype none

module integer_to_ascii_radix
   import i2a_pkg::*;
#(
   parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire req_payload_type req_payload,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output rsp_payload_type      rsp_payload
);

   localparam int ADDR_W = $clog2(WORD_BITS);
   localparam int CNT_W  = $clog2(WORD_BITS + 1);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_DIV  = 5'b00010,
      ST_SIGN = 5'b00100,
      ST_READ = 5'b01000,
      ST_EMIT = 5'b10000
   } state_type;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [RADIX_W-1:0]   base_ff, base_in;
   logic                 neg_ff, neg_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_payload_type      rsp_data_ff, rsp_data_in;

   logic                 accept;
   logic                 out_free;
   logic [RADIX_W-1:0]   base_sat;
   logic [WORD_BITS-1:0] word;
   logic                 word_neg;
   logic [WORD_BITS-1:0] mag;
   logic [CNT_W-1:0]     count_dec;

   logic                 div_start;
   logic [WORD_BITS-1:0] div_dividend;
   logic [WORD_BITS-1:0] div_quotient;
   logic [RADIX_W-1:0]   div_remainder;
   div_status_type       div_status;

   logic                 st_wr_en;
   logic                 st_rd_en;
   logic [RADIX_W-1:0]   st_rd_data;

   // Request decode: saturate base, pick sign and magnitude
   always_comb begin
      if (req_payload.radix < RADIX_MIN) begin
         base_sat = RADIX_MIN;
      end else if (req_payload.radix > RADIX_MAX) begin
         base_sat = RADIX_MAX;
      end else begin
         base_sat = req_payload.radix;
      end
      word     = WORD_BITS'(req_payload.value);
      word_neg = req_payload.signed_mode && (base_sat == RADIX_DEC) && word[WORD_BITS-1];
      mag      = word_neg ? (~word + WORD_BITS'(1)) : word;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign count_dec = count_ff - CNT_W'(1);

   // Divider kick: first pass on accept, again while quotient is nonzero
   assign div_start    = accept ||
                         ((state_ff == ST_DIV) && div_status.done && !div_status.quo_zero);
   assign div_dividend = accept ? mag : div_quotient;
   assign st_wr_en     = (state_ff == ST_DIV) && div_status.done;
   assign st_rd_en     = (state_ff == ST_READ);

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      base_in      = base_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               base_in  = base_sat;
               neg_in   = word_neg;
               count_in = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_status.done) begin
               count_in = count_ff + CNT_W'(1);
               if (div_status.quo_zero) begin
                  state_in = neg_ff ? ST_SIGN : ST_READ;
               end
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.character = CHAR_MINUS;
               rsp_data_in.last      = 1'b0;
               state_in              = ST_READ;
            end
         end
         ST_READ: begin
            count_in = count_dec;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.character = digit_char(st_rd_data);
               rsp_data_in.last      = (count_ff == '0);
               state_in              = (count_ff == '0) ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working registers and output payload
   always_ff @(posedge clock) begin
      count_ff    <= count_in;
      base_ff     <= base_in;
      neg_ff      <= neg_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   i2a_div #(
      .WORD_BITS (WORD_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (accept ? base_sat : base_ff),
      .quotient  (div_quotient),
      .remainder (div_remainder),
      .status    (div_status)
   );

   i2a_digit_stack #(
      .WORD_BITS (WORD_BITS)
   ) u_stack (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (div_remainder),
      .rd_en   (st_rd_en),
      .rd_addr (count_dec[ADDR_W-1:0]),
      .rd_data (st_rd_data)
   );

endmodule

`default_nettype wire

[hw/rtl/i2a_checker.sv]
// Port-level checker for integer_to_ascii_radix and its bind statement.
// Depends on i2a_pkg and integer_to_ascii_radix_macros.svh.
`default_nettype none
`include "integer_to_ascii_radix_macros.svh"

module i2a_checker
   import i2a_pkg::*;
(
   input wire logic            clock,
   input wire logic            reset,
   input wire logic            req_valid,
   input wire logic            req_ready,
   input wire req_payload_type req_payload,
   input wire logic            rsp_valid,
   input wire logic            rsp_ready,
   input wire rsp_payload_type rsp_payload
);

   // A stalled result transfer holds
   `I2A_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))

   // A conversion keeps the request side closed on the following cycle
   `I2A_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)

   // While a non-final character is shown, the conversion is still running
   `I2A_ASSERT_NOW(a_mid_string_busy, rsp_valid && !rsp_payload.last, !req_ready)

   // The sign never ends a string
   `I2A_ASSERT_NOW(a_sign_not_last, rsp_valid && (rsp_payload.character == CHAR_MINUS),
      !rsp_payload.last)

endmodule

bind integer_to_ascii_radix i2a_checker u_checker (.*);

`default_nettype wire
